// ----- rtl/clmd_pkg.sv -----
// Shared types, constants and helper functions of the Coulomb and laser motion derivative block.
package clmd_pkg;

    localparam int SQRT_STAGES = 32;
    localparam int UDIV_STAGES = 17;
    localparam int QDIV_STAGES = 33;
    localparam int COUL_LAT    = 2 + SQRT_STAGES + UDIV_STAGES + 1 + QDIV_STAGES;
    localparam int MOD_STAGES  = 29;
    localparam int LASER_CORE  = 3 + MOD_STAGES + 3 + 13 + 2;
    localparam int LASER_PAD   = COUL_LAT - LASER_CORE;

    localparam logic [63:0] ANG_TWO_PI        = 64'd26986075409;
    localparam logic [34:0] ANG_PI            = 35'd13493037705;
    localparam logic [34:0] ANG_HALF_PI       = 35'd6746518852;
    localparam logic [34:0] ANG_THREE_HALF_PI = 35'd20239556557;
    localparam logic [30:0] COS_ONE           = 31'd1073741824;

    // reciprocal constants for the series divisions, scaled by 2^32
    localparam logic [6:0]  DIV_FIRST_D = 7'd90;
    localparam logic [28:0] DIV_FIRST_M = 29'((64'd1 << 32) / 90);
    localparam logic [6:0]  DIV_D [3] = '{7'd56, 7'd30, 7'd12};
    localparam logic [28:0] DIV_M [3] = '{29'((64'd1 << 32) / 56),
                                          29'((64'd1 << 32) / 30),
                                          29'((64'd1 << 32) / 12)};

    typedef enum logic [2:0] {
        CFG_CHARGE    = 3'd0,
        CFG_FIELD_EN  = 3'd1,
        CFG_AMPLITUDE = 3'd2,
        CFG_OMEGA     = 3'd3,
        CFG_PHASE     = 3'd4
    } clmd_cfg_t;

    typedef struct packed {
        logic        enable;
        logic [30:0] amplitude;
        logic [30:0] omega;
        logic [31:0] phase;
    } clmd_laser_cfg_t;

    typedef struct packed {
        logic [2:0][32:0] quot;
        logic [2:0]       ovf;
        logic [2:0]       pos;
        logic [2:0]       nz;
        logic             zr;
    } clmd_coul_t;

    // quotient estimate, low by at most one
    function automatic logic [31:0] clmd_dc_est(input logic [31:0] x, input logic [28:0] m);
        logic [60:0] p;
        p = {29'd0, x} * {32'd0, m};
        return {3'd0, p[60:32]};
    endfunction

    function automatic logic [31:0] clmd_dc_fix(input logic [31:0] x, input logic [31:0] q0,
                                                input logic [6:0] d);
        logic [38:0] qd;
        logic [38:0] rem;
        qd  = {7'd0, q0} * {32'd0, d};
        rem = {7'd0, x} - qd;
        return q0 + {31'd0, (rem >= {32'd0, d})};
    endfunction

endpackage

// ----- rtl/coulomb_laser_motion_derivative.sv -----
// Top level: configuration registers, beat pipeline control, final sum and saturation.
// Throughput: one beat per cycle while the output is not stalled; the square root and
// the two dividers are pipelined one quotient or root bit per stage, which sets the
// depth.
// A stalled output holds the whole pipeline; s_tready is high whenever the output is free.
// Reset (aresetn low, synchronous) empties the pipeline and loads the register defaults.
module coulomb_laser_motion_derivative (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [223:0] s_tdata,   // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, sim_time
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [191:0] m_tdata,   // rate_x, rate_y, rate_z, accel_x, accel_y, accel_z
    output logic [0:0]   m_tuser,   // saturated
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int LAT = clmd_pkg::COUL_LAT;

    logic [30:0] charge_reg;
    logic        field_en_reg;
    logic [30:0] amplitude_reg;
    logic [30:0] omega_reg;
    logic [31:0] phase_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            charge_reg    <= 31'd65536;
            field_en_reg  <= 1'b0;
            amplitude_reg <= 31'd1250;
            omega_reg     <= 31'd2807;
            phase_reg     <= 32'd0;
        end else if (cfg_we) begin
            unique case (clmd_pkg::clmd_cfg_t'(cfg_index))
                clmd_pkg::CFG_CHARGE:    charge_reg    <= cfg_data[30:0];
                clmd_pkg::CFG_FIELD_EN:  field_en_reg  <= cfg_data[0];
                clmd_pkg::CFG_AMPLITUDE: amplitude_reg <= cfg_data[30:0];
                clmd_pkg::CFG_OMEGA:     omega_reg     <= cfg_data[30:0];
                clmd_pkg::CFG_PHASE:     phase_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    logic en;
    logic m_tvalid_reg;

    // advance unless a result beat is stuck at the output; take no beat during reset
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en && aresetn;

    clmd_pkg::clmd_laser_cfg_t laser_cfg;
    clmd_pkg::clmd_coul_t      coul;
    logic signed [33:0]        field;
    logic [2:0][31:0]          pos_in;

    assign laser_cfg.enable    = field_en_reg;
    assign laser_cfg.amplitude = amplitude_reg;
    assign laser_cfg.omega     = omega_reg;
    assign laser_cfg.phase     = phase_reg;
    assign pos_in              = s_tdata[95:0];

    clmd_coulomb u_coulomb (
        .aclk   (aclk),
        .en     (en),
        .pos_in (pos_in),
        .charge (charge_reg),
        .coul   (coul)
    );

    clmd_laser u_laser (
        .aclk     (aclk),
        .en       (en),
        .sim_time (s_tdata[223:192]),
        .cfg      (laser_cfg),
        .field    (field)
    );

    logic [LAT-1:0] vld_reg;
    logic [95:0]    vel_reg [LAT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vel_reg[0] <= s_tdata[191:96];
            for (int i = 1; i < LAT; i++) begin
                vel_reg[i] <= vel_reg[i - 1];
            end
        end
    end

    // combine Coulomb terms with the field term, then clamp
    logic [2:0][31:0] accel;
    logic             sat_flag;

    always_comb begin
        logic [32:0]        qc;
        logic signed [34:0] term;
        logic signed [34:0] acc;
        sat_flag = coul.zr;
        for (int i = 0; i < 3; i++) begin
            qc = (coul.ovf[i] || coul.quot[i] > 33'h1_0000_0000) ? 33'h1_0000_0000
                                                                 : coul.quot[i];
            if (coul.zr || !coul.nz[i]) begin
                term = 35'sd0;
            end else if (coul.pos[i]) begin
                term = -$signed({2'b00, qc});
            end else begin
                term = $signed({2'b00, qc});
            end
            acc = (i == 2) ? (term + 35'(field)) : term;
            if (acc > 35'sd2147483647) begin
                accel[i] = 32'h7FFF_FFFF;
                sat_flag = 1'b1;
            end else if (acc < -35'sd2147483648) begin
                accel[i] = 32'h8000_0000;
                sat_flag = 1'b1;
            end else begin
                accel[i] = acc[31:0];
            end
        end
    end

    logic [191:0] m_data_reg;
    logic         m_user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= vld_reg[LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= {accel, vel_reg[LAT - 1]};
            m_user_reg <= sat_flag;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_user_reg;

endmodule

// ----- rtl/clmd_coulomb.sv -----
// Coulomb path: squared radius, pipelined square root and two pipelined dividers.
module clmd_coulomb (
    input  logic                    aclk,
    input  logic                    en,
    input  logic [2:0][31:0]        pos_in,
    input  logic [30:0]             charge,
    output clmd_pkg::clmd_coul_t    coul
);

    typedef struct packed {
        logic [2:0][31:0] pmag;
        logic [2:0]       pos;
        logic [2:0]       nz;
        logic             zr;
        logic [63:0]      r2;
    } side_t;

    localparam int SQ = clmd_pkg::SQRT_STAGES;
    localparam int UD = clmd_pkg::UDIV_STAGES;
    localparam int QD = clmd_pkg::QDIV_STAGES;

    // squares
    logic [2:0][63:0] sq_reg;
    logic [2:0][31:0] pmag_reg;
    logic [2:0]       pos_reg;
    logic [2:0]       nz_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                logic [31:0] m;
                m = pos_in[i][31] ? (~pos_in[i] + 32'd1) : pos_in[i];
                pmag_reg[i] <= m;
                sq_reg[i]   <= {32'd0, m} * {32'd0, m};
                pos_reg[i]  <= !pos_in[i][31] && (pos_in[i] != 32'd0);
                nz_reg[i]   <= (pos_in[i] != 32'd0);
            end
        end
    end

    // sum
    side_t c2_side_reg;
    logic [63:0] r2_sum;

    assign r2_sum = sq_reg[0] + sq_reg[1] + sq_reg[2];

    always_ff @(posedge aclk) begin
        if (en) begin
            c2_side_reg.pmag <= pmag_reg;
            c2_side_reg.pos  <= pos_reg;
            c2_side_reg.nz   <= nz_reg;
            c2_side_reg.r2   <= r2_sum;
            c2_side_reg.zr   <= (r2_sum == 64'd0);
        end
    end

    // square root, one result bit per stage
    logic [63:0] rt_rem_reg  [SQ];
    logic [63:0] rt_root_reg [SQ];
    side_t       rt_side_reg [SQ];

    for (genvar k = 0; k < SQ; k++) begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic [63:0] rem_in, root_in, rem_next, root_next, trial;
        side_t       side_in;
        if (k == 0) begin : g_head
            assign rem_in  = c2_side_reg.r2;
            assign root_in = 64'd0;
            assign side_in = c2_side_reg;
        end else begin : g_link
            assign rem_in  = rt_rem_reg[k - 1];
            assign root_in = rt_root_reg[k - 1];
            assign side_in = rt_side_reg[k - 1];
        end
        always_comb begin
            trial = root_in + BIT;
            if (rem_in >= trial) begin
                rem_next  = rem_in - trial;
                root_next = (root_in >> 1) + BIT;
            end else begin
                rem_next  = rem_in;
                root_next = root_in >> 1;
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                rt_rem_reg[k]  <= rem_next;
                rt_root_reg[k] <= root_next;
                rt_side_reg[k] <= side_in;
            end
        end
    end

    // U = |p| * 2^16 / R, restoring, one quotient bit per stage
    logic [2:0][47:0] ud_rem_reg  [UD];
    logic [2:0][16:0] ud_q_reg    [UD];
    logic [31:0]      ud_root_reg [UD];
    side_t            ud_side_reg [UD];

    for (genvar d = 0; d < UD; d++) begin : g_udiv
        localparam int J = UD - 1 - d;
        logic [2:0][47:0] rem_in, rem_next;
        logic [2:0][16:0] q_in, q_next;
        logic [31:0]      root_in;
        side_t            side_in;
        if (d == 0) begin : g_head
            assign side_in = rt_side_reg[SQ - 1];
            assign root_in = rt_root_reg[SQ - 1][31:0];
            always_comb begin
                for (int i = 0; i < 3; i++) begin
                    rem_in[i] = {side_in.pmag[i], 16'd0};
                    q_in[i]   = 17'd0;
                end
            end
        end else begin : g_link
            assign side_in = ud_side_reg[d - 1];
            assign root_in = ud_root_reg[d - 1];
            assign rem_in  = ud_rem_reg[d - 1];
            assign q_in    = ud_q_reg[d - 1];
        end
        always_comb begin
            for (int i = 0; i < 3; i++) begin
                if ((rem_in[i] >> J) >= {16'd0, root_in}) begin
                    rem_next[i] = rem_in[i] - ({16'd0, root_in} << J);
                    q_next[i]   = q_in[i] | (17'd1 << J);
                end else begin
                    rem_next[i] = rem_in[i];
                    q_next[i]   = q_in[i];
                end
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                ud_rem_reg[d]  <= rem_next;
                ud_q_reg[d]    <= q_next;
                ud_root_reg[d] <= root_in;
                ud_side_reg[d] <= side_in;
            end
        end
    end

    // K * U * 2^16
    logic [2:0][63:0] mu_num_reg;
    side_t            mu_side_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                logic [47:0] p;
                p = {17'd0, charge} * {31'd0, ud_q_reg[UD - 1][i]};
                mu_num_reg[i] <= {p, 16'd0};
            end
            mu_side_reg <= ud_side_reg[UD - 1];
        end
    end

    // Q = num / R2, quotient bits 32 down to 0; a quotient of 2^33 or more is flagged
    logic [2:0][63:0] qd_rem_reg  [QD];
    logic [2:0][32:0] qd_q_reg    [QD];
    logic [2:0]       qd_ovf_reg  [QD];
    side_t            qd_side_reg [QD];

    for (genvar e = 0; e < QD; e++) begin : g_qdiv
        localparam int J = QD - 1 - e;
        logic [2:0][63:0] rem_in, rem_next;
        logic [2:0][32:0] q_in, q_next;
        logic [2:0]       ovf_in;
        side_t            side_in;
        if (e == 0) begin : g_head
            assign side_in = mu_side_reg;
            assign rem_in  = mu_num_reg;
            always_comb begin
                for (int i = 0; i < 3; i++) begin
                    q_in[i]   = 33'd0;
                    ovf_in[i] = (mu_num_reg[i] >> QD) >= mu_side_reg.r2;
                end
            end
        end else begin : g_link
            assign side_in = qd_side_reg[e - 1];
            assign rem_in  = qd_rem_reg[e - 1];
            assign q_in    = qd_q_reg[e - 1];
            assign ovf_in  = qd_ovf_reg[e - 1];
        end
        always_comb begin
            for (int i = 0; i < 3; i++) begin
                if ((rem_in[i] >> J) >= side_in.r2) begin
                    rem_next[i] = rem_in[i] - (side_in.r2 << J);
                    q_next[i]   = q_in[i] | (33'd1 << J);
                end else begin
                    rem_next[i] = rem_in[i];
                    q_next[i]   = q_in[i];
                end
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                qd_rem_reg[e]  <= rem_next;
                qd_q_reg[e]    <= q_next;
                qd_ovf_reg[e]  <= ovf_in;
                qd_side_reg[e] <= side_in;
            end
        end
    end

    assign coul.quot = qd_q_reg[QD - 1];
    assign coul.ovf  = qd_ovf_reg[QD - 1];
    assign coul.pos  = qd_side_reg[QD - 1].pos;
    assign coul.nz   = qd_side_reg[QD - 1].nz;
    assign coul.zr   = qd_side_reg[QD - 1].zr;

endmodule

// ----- rtl/clmd_laser.sv -----
// Laser path: phase angle, range reduction, cosine series and amplitude scaling.
module clmd_laser (
    input  logic                         aclk,
    input  logic                         en,
    input  logic [31:0]                  sim_time,
    input  clmd_pkg::clmd_laser_cfg_t    cfg,
    output logic signed [33:0]           field
);

    localparam int MS = clmd_pkg::MOD_STAGES;
    localparam int PD = clmd_pkg::LASER_PAD;

    // angle = omega * t + phase * 2^16
    logic signed [63:0] prod_reg;
    logic signed [63:0] ang_reg;
    logic [63:0]        amag_reg;
    logic               aneg_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= $signed({1'b0, cfg.omega}) * $signed(sim_time);
            ang_reg  <= prod_reg + $signed({{16{cfg.phase[31]}}, cfg.phase, 16'd0});
            amag_reg <= ang_reg[63] ? (~ang_reg + 64'd1) : ang_reg;
            aneg_reg <= ang_reg[63];
        end
    end

    // |angle| mod 2*pi, one compare and subtract per stage
    logic [63:0] mr_reg   [MS];
    logic        mneg_reg [MS];

    for (genvar t = 0; t < MS; t++) begin : g_mod
        localparam logic [63:0] LIMIT = clmd_pkg::ANG_TWO_PI << (MS - 1 - t);
        logic [63:0] r_in;
        logic        n_in;
        if (t == 0) begin : g_head
            assign r_in = amag_reg;
            assign n_in = aneg_reg;
        end else begin : g_link
            assign r_in = mr_reg[t - 1];
            assign n_in = mneg_reg[t - 1];
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                mr_reg[t]   <= (r_in >= LIMIT) ? (r_in - LIMIT) : r_in;
                mneg_reg[t] <= n_in;
            end
        end
    end

    // map to [0, 2*pi), then fold to |theta| <= pi/2
    logic [34:0] m_reg;
    logic [32:0] thabs_reg;
    logic        cneg_f_reg;
    logic [34:0] r_last;
    logic [34:0] th_fold;
    logic        cneg_fold;

    assign r_last = mr_reg[MS - 1][34:0];

    always_comb begin
        cneg_fold = 1'b0;
        if (m_reg < clmd_pkg::ANG_HALF_PI) begin
            th_fold = m_reg;
        end else if (m_reg < clmd_pkg::ANG_THREE_HALF_PI) begin
            cneg_fold = 1'b1;
            th_fold = (m_reg >= clmd_pkg::ANG_PI) ? (m_reg - clmd_pkg::ANG_PI)
                                                  : (clmd_pkg::ANG_PI - m_reg);
        end else begin
            th_fold = clmd_pkg::ANG_TWO_PI[34:0] - m_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_reg      <= (mneg_reg[MS - 1] && r_last != 35'd0)
                          ? (clmd_pkg::ANG_TWO_PI[34:0] - r_last) : r_last;
            thabs_reg  <= th_fold[32:0];
            cneg_f_reg <= cneg_fold;
        end
    end

    // s = theta^2 in Q30
    logic [31:0] s_reg;
    logic        cneg_s_reg;
    logic [61:0] usq;

    assign usq = {31'd0, thabs_reg[32:2]} * {31'd0, thabs_reg[32:2]};

    always_ff @(posedge aclk) begin
        if (en) begin
            s_reg      <= usq[61:30];
            cneg_s_reg <= cneg_f_reg;
        end
    end

    // first series term: h = 1 - s/90
    logic [31:0] t1_q0_reg, t1_s_reg;
    logic        t1_cn_reg;
    logic [30:0] h_reg  [4];
    logic [31:0] hs_reg [4];
    logic        hc_reg [4];

    always_ff @(posedge aclk) begin
        if (en) begin
            t1_q0_reg <= clmd_pkg::clmd_dc_est(s_reg, clmd_pkg::DIV_FIRST_M);
            t1_s_reg  <= s_reg;
            t1_cn_reg <= cneg_s_reg;
            h_reg[0]  <= clmd_pkg::COS_ONE
                         - 31'(clmd_pkg::clmd_dc_fix(t1_s_reg, t1_q0_reg,
                                                     clmd_pkg::DIV_FIRST_D));
            hs_reg[0] <= t1_s_reg;
            hc_reg[0] <= t1_cn_reg;
        end
    end

    // next terms: h = 1 - (s*h)/d, three stages each
    logic [62:0] tp_reg  [3];
    logic [31:0] tps_reg [3];
    logic        tpc_reg [3];
    logic [31:0] tx_reg  [3];
    logic [31:0] tq_reg  [3];
    logic [31:0] txs_reg [3];
    logic        txc_reg [3];

    for (genvar g = 0; g < 3; g++) begin : g_term
        always_ff @(posedge aclk) begin
            if (en) begin
                tp_reg[g]    <= {31'd0, hs_reg[g]} * {32'd0, h_reg[g]};
                tps_reg[g]   <= hs_reg[g];
                tpc_reg[g]   <= hc_reg[g];
                tx_reg[g]    <= tp_reg[g][61:30];
                tq_reg[g]    <= clmd_pkg::clmd_dc_est(tp_reg[g][61:30], clmd_pkg::DIV_M[g]);
                txs_reg[g]   <= tps_reg[g];
                txc_reg[g]   <= tpc_reg[g];
                h_reg[g + 1] <= clmd_pkg::COS_ONE
                                - 31'(clmd_pkg::clmd_dc_fix(tx_reg[g], tq_reg[g],
                                                            clmd_pkg::DIV_D[g]));
                hs_reg[g + 1] <= txs_reg[g];
                hc_reg[g + 1] <= txc_reg[g];
            end
        end
    end

    // last term: c = 1 - (s*h)/2
    logic [62:0]        pf_reg;
    logic               pfc_reg;
    logic [31:0]        cmag_reg;
    logic               fpos_reg;
    logic signed [32:0] craw;

    assign craw = 33'sd1073741824 - $signed({1'b0, pf_reg[62:31]});

    always_ff @(posedge aclk) begin
        if (en) begin
            pf_reg   <= {31'd0, hs_reg[3]} * {32'd0, h_reg[3]};
            pfc_reg  <= hc_reg[3];
            cmag_reg <= craw[32] ? 32'(-craw) : craw[31:0];
            // field term is positive when the cosine is negative
            fpos_reg <= pfc_reg ? (craw > 33'sd0) : craw[32];
        end
    end

    // amplitude scaling and sign
    logic [62:0]        fprod_reg;
    logic               fsgn_reg;
    logic signed [33:0] field_reg;
    logic signed [33:0] field_val;

    always_comb begin
        if (!cfg.enable) begin
            field_val = 34'sd0;
        end else if (fsgn_reg) begin
            field_val = $signed({1'b0, fprod_reg[62:30]});
        end else begin
            field_val = -$signed({1'b0, fprod_reg[62:30]});
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fprod_reg <= {32'd0, cfg.amplitude} * {31'd0, cmag_reg};
            fsgn_reg  <= fpos_reg;
            field_reg <= field_val;
        end
    end

    // align with the Coulomb path
    logic signed [33:0] pad_reg [PD];

    always_ff @(posedge aclk) begin
        if (en) begin
            pad_reg[0] <= field_reg;
            for (int i = 1; i < PD; i++) begin
                pad_reg[i] <= pad_reg[i - 1];
            end
        end
    end

    assign field = pad_reg[PD - 1];

endmodule

// ----- rtl/clmd_checker.sv -----
// Port-level checks of the motion derivative block, bound to the top level.
module clmd_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [191:0] m_tdata,
    input logic [0:0]   m_tuser
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_ready_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    a_ready_on_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready |-> s_tready)
        else $error("input stalled while output drains");

endmodule

bind coulomb_laser_motion_derivative clmd_checker u_clmd_checker (.*);

// ----- tb/sv/coulomb_laser_motion_derivative_tb.sv -----
// Self-checking testbench for the Coulomb and laser motion derivative block.
`timescale 1ns / 100ps

module coulomb_laser_motion_derivative_tb;

    localparam int LATENCY   = 86;
    localparam int MAX_CYCLE = 1500000;

    typedef struct packed {
        logic signed [31:0] sim_time;
        logic signed [31:0] vel_z;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] pos_z;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_x;
    } state_beat_t;

    typedef struct packed {
        logic        saturated;
        logic [31:0] accel_z;
        logic [31:0] accel_y;
        logic [31:0] accel_x;
        logic [31:0] rate_z;
        logic [31:0] rate_y;
        logic [31:0] rate_x;
    } deriv_beat_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [223:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [191:0] m_tdata;
    logic [0:0]   m_tuser;
    logic         cfg_we = 1'b0;
    logic [2:0]   cfg_index = '0;
    logic [31:0]  cfg_data = '0;

    coulomb_laser_motion_derivative u_top (.*);

    always #5 aclk = ~aclk;

    // predictor copy of the registers
    logic [63:0] k_charge, amp, omega;
    logic        fld_en;
    logic [31:0] phase;

    state_beat_t pending_states[$];
    deriv_beat_t expected_derivs[$];
    int          errors = 0;
    int          cycles = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] rem, root, bit_w;
        rem = v; root = 0; bit_w = 64'd1 << 62;
        while (bit_w > rem) bit_w >>= 2;
        while (bit_w != 0) begin
            if (rem >= root + bit_w) begin
                rem -= root + bit_w;
                root = (root >> 1) + bit_w;
            end else begin
                root >>= 1;
            end
            bit_w >>= 2;
        end
        return root;
    endfunction

    function automatic logic [63:0] magnitude(input longint v);
        return v < 0 ? 64'd0 - 64'(v) : 64'(v);
    endfunction

    function automatic longint cos_q30(input longint ang);
        longint m, th, c;
        logic [63:0] u, s, h;
        bit neg;
        neg = 0;
        m = ang % 64'sd26986075409;
        if (m < 0) m += 64'sd26986075409;
        if (m < 64'sd6746518852) th = m;
        else if (m < 64'sd20239556557) begin
            th = m - 64'sd13493037705;
            neg = 1;
        end else th = m - 64'sd26986075409;
        u = magnitude(th) >> 2;
        s = (u * u) >> 30;
        h = (64'd1 << 30) - s / 90;
        h = (64'd1 << 30) - ((s * h) >> 30) / 56;
        h = (64'd1 << 30) - ((s * h) >> 30) / 30;
        h = (64'd1 << 30) - ((s * h) >> 30) / 12;
        c = longint'(64'd1 << 30) - longint'(((s * h) >> 30) / 2);
        return neg ? -c : c;
    endfunction

    function automatic deriv_beat_t motion_derivative(input state_beat_t st);
        deriv_beat_t d;
        longint p[3], acc[3], ang, c, v;
        logic [63:0] r2, r, u, q, f;
        bit flag;
        p[0] = st.pos_x; p[1] = st.pos_y; p[2] = st.pos_z;
        r2 = 0; flag = 0;
        for (int i = 0; i < 3; i++) r2 += magnitude(p[i]) * magnitude(p[i]);
        r = int_sqrt(r2);
        for (int i = 0; i < 3; i++) begin
            acc[i] = 0;
            if (r != 0 && p[i] != 0) begin
                u = (magnitude(p[i]) << 16) / r;
                q = ((k_charge * u) << 16) / r2;
                if (q > (64'd1 << 32)) q = 64'd1 << 32;
                acc[i] = p[i] > 0 ? -longint'(q) : longint'(q);
            end
        end
        if (r == 0) flag = 1;
        if (fld_en) begin
            ang = longint'(omega) * longint'(st.sim_time)
                + longint'($signed(phase)) * 65536;
            c = cos_q30(ang);
            f = (amp * magnitude(c)) >> 30;
            acc[2] += c < 0 ? longint'(f) : -longint'(f);
        end
        for (int i = 0; i < 3; i++) begin
            v = acc[i];
            if (v > 64'sd2147483647) begin
                v = 64'sd2147483647; flag = 1;
            end else if (v < -64'sd2147483648) begin
                v = -64'sd2147483648; flag = 1;
            end
            acc[i] = v;
        end
        d.rate_x = st.vel_x; d.rate_y = st.vel_y; d.rate_z = st.vel_z;
        d.accel_x = acc[0][31:0]; d.accel_y = acc[1][31:0]; d.accel_z = acc[2][31:0];
        d.saturated = flag;
        return d;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        errors++;
    endtask

    // driver: predict on acceptance, advance queue
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_derivs.insert(expected_derivs.size(), motion_derivative(s_tdata));
                void'(pending_states.pop_front());
            end
            if (pending_states.size() > (s_tvalid && s_tready ? 0 : 0) &&
                !(s_tvalid && !s_tready)) begin
                if (pending_states.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_states[0];
                end else begin
                    s_tvalid <= 1'b0;
                end
            end else if (pending_states.size() == 0) begin
                s_tvalid <= 1'b0;
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor
    always @(posedge aclk) begin
        deriv_beat_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tuser, m_tdata};
            if (expected_derivs.size() == 0) begin
                report_mismatch("unexpected beat", m_tdata[31:0], 32'd0);
            end else begin
                want = expected_derivs.pop_front();
                if (got.rate_x !== want.rate_x) report_mismatch("rate_x", got.rate_x, want.rate_x);
                if (got.rate_y !== want.rate_y) report_mismatch("rate_y", got.rate_y, want.rate_y);
                if (got.rate_z !== want.rate_z) report_mismatch("rate_z", got.rate_z, want.rate_z);
                if (got.accel_x !== want.accel_x)
                    report_mismatch("accel_x", got.accel_x, want.accel_x);
                if (got.accel_y !== want.accel_y)
                    report_mismatch("accel_y", got.accel_y, want.accel_y);
                if (got.accel_z !== want.accel_z)
                    report_mismatch("accel_z", got.accel_z, want.accel_z);
                if (got.saturated !== want.saturated)
                    report_mismatch("saturated", 32'(got.saturated), 32'(want.saturated));
            end
        end
    end

    always @(posedge aclk) begin
        if (cycles >= MAX_CYCLE) begin
            $display("coulomb_laser_motion_derivative verification failed");
            $finish;
        end
    end

    task automatic write_reg(input clmd_pkg::clmd_cfg_t idx, input logic [31:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            clmd_pkg::CFG_CHARGE:    k_charge = {33'd0, val[30:0]};
            clmd_pkg::CFG_FIELD_EN:  fld_en = val[0];
            clmd_pkg::CFG_AMPLITUDE: amp = {33'd0, val[30:0]};
            clmd_pkg::CFG_OMEGA:     omega = {33'd0, val[30:0]};
            clmd_pkg::CFG_PHASE:     phase = val;
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain;
        while (pending_states.size() != 0 || expected_derivs.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000);
            2: return 32'($signed($urandom_range(0, 32'h03ffffff)) - 32'sh02000000);
            default: return $urandom_range(0, 2) == 0 ? 32'd0 : $urandom_range(0, 255);
        endcase
    endfunction

    task automatic queue_state(input logic [31:0] x, y, z, t);
        state_beat_t st;
        st.pos_x = x; st.pos_y = y; st.pos_z = z;
        st.vel_x = $urandom; st.vel_y = $urandom; st.vel_z = $urandom;
        st.sim_time = t;
        pending_states.insert(pending_states.size(), st);
    endtask

    initial begin
        k_charge = 65536; fld_en = 0; amp = 1250; omega = 2807; phase = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: zero radius, extremes, tiny radius overflow, axis points
        queue_state(0, 0, 0, 0);
        queue_state(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
        queue_state(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        queue_state(1, 0, 0, 0);
        queue_state(0, 32'hffffffff, 0, 0);
        queue_state(0, 0, 32'h00010000, 0);
        queue_state(32'h00010000, 32'hffff0000, 32'h00008000, 32'h00050000);
        queue_state(32'h80000000, 0, 1, 32'h7fffffff);
        drain();
        write_reg(clmd_pkg::CFG_FIELD_EN, 1);
        queue_state(0, 0, 0, 0);
        queue_state(0, 0, 0, 32'h80000000);
        queue_state(0, 0, 0, 32'h7fffffff);
        queue_state(32'h00020000, 0, 32'hfffe0000, 32'h00640000);
        drain();
        write_reg(clmd_pkg::CFG_CHARGE, 32'h7fffffff);
        write_reg(clmd_pkg::CFG_AMPLITUDE, 32'h7fffffff);
        write_reg(clmd_pkg::CFG_OMEGA, 32'h7fffffff);
        write_reg(clmd_pkg::CFG_PHASE, 32'h80000000);
        queue_state(0, 0, 0, 32'h12345678);
        queue_state(3, 0, 0, 32'hfedcba98);
        queue_state(32'h00100000, 32'h00100000, 32'h00100000, 32'h7fffffff);
        drain();
        write_reg(clmd_pkg::CFG_PHASE, 32'h7fffffff);
        queue_state(0, 1, 0, 32'h80000000);
        queue_state(0, 0, 0, 32'h00003000);
        drain();
        write_reg(clmd_pkg::CFG_CHARGE, 0);
        write_reg(clmd_pkg::CFG_AMPLITUDE, 0);
        write_reg(clmd_pkg::CFG_OMEGA, 0);
        queue_state(0, 0, 0, 5);
        queue_state(32'h00010000, 0, 0, 5);
        drain();

        // random phases: no idle, sender idle, receiver stall, both
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(clmd_pkg::CFG_CHARGE, ph == 0 ? 32'h7fffffff : $urandom);
            write_reg(clmd_pkg::CFG_FIELD_EN, 32'(ph % 3 != 0));
            write_reg(clmd_pkg::CFG_AMPLITUDE, ph == 1 ? 32'h7fffffff : $urandom);
            write_reg(clmd_pkg::CFG_OMEGA, ph == 2 ? 0 : $urandom);
            write_reg(clmd_pkg::CFG_PHASE, $urandom);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
                default: begin send_idle_pct = 17; recv_stall_pct = 17; end
            endcase
            for (int n = 0; n < 300; n++)
                queue_state(rand_coord(), rand_coord(), rand_coord(), $urandom);
            // hold off until everything has come back once
            if (ph == 3) begin
                while (pending_states.size() > 150) @(posedge aclk);
                send_idle_pct = 100;
                while (expected_derivs.size() != 0) @(posedge aclk);
                send_idle_pct = 17;
            end
            drain();
        end

        if (errors == 0) begin
            $display("coulomb_laser_motion_derivative verification clean");
        end else begin
            $display("coulomb_laser_motion_derivative verification failed");
        end
        $finish;
    end

endmodule
